// ----- design/tlcs_pkg.sv -----
// Package for the triangle LFO curve shaper: state codes, register indexes, curve mode
// codes, opcodes, the 2^-k/16 table. No dependencies.
package tlcs_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_FOLD, ST_SHAPE1, ST_SHAPE2, ST_KEY, ST_KDIV,
    ST_CLAMP, ST_LVL, ST_OUT
  } state_t;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_MODE   = 3'd1;
  localparam logic [2:0] REG_START  = 3'd2;
  localparam logic [2:0] REG_END    = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;
  localparam logic [2:0] REG_KCOUNT = 3'd5;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_RUBBER = 2'd2;
  localparam logic [1:0] MODE_KEY    = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  function automatic logic [16:0] exp2_neg(input logic [4:0] k);
    logic [16:0] r;
    case (k)
      5'd0: r = 17'd65536;  5'd1: r = 17'd62757;  5'd2: r = 17'd60097;
      5'd3: r = 17'd57549;  5'd4: r = 17'd55109;  5'd5: r = 17'd52773;
      5'd6: r = 17'd50535;  5'd7: r = 17'd48393;  5'd8: r = 17'd46341;
      5'd9: r = 17'd44376;  5'd10: r = 17'd42495; 5'd11: r = 17'd40693;
      5'd12: r = 17'd38968; 5'd13: r = 17'd37316; 5'd14: r = 17'd35734;
      5'd15: r = 17'd34219; default: r = 17'd32768;
    endcase
    return r;
  endfunction
endpackage

// ----- design/tlcs_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, unsigned.
// Uses no package items.
module tlcs_divider #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem[W-1:0], quotient[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
        count    <= CW'(W);
      end else if (busy) begin
        if (!trial[W]) begin
          rem      <= trial[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          rem      <= {rem[W-2:0], quotient[W-1]};
          quotient <= {quotient[W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/triangle_lfo_curve_shaper.sv -----
// Triangle LFO curve shaper around one shared multiplier; uses tlcs_pkg, tlcs_divider.
// Tick sequence: MUL, FOLD, then no shaping state (linear), SHAPE1 (rubberband), SHAPE1 and SHAPE2
// (smoothstep) or KEY once per segment scanned plus KDIV for the serial divide when a segment is
// interpolated (keyframe), then CLAMP, LVL and OUT. Loads and disabled ticks leave the block in IDLE, no result.
// One item at a time; after a tick, tready stays low until the result is taken.
// Reset (rst, synchronous) clears config registers, state and phase; keyframes and datapath registers stay undefined.
module triangle_lfo_curve_shaper #(
  parameter int MAX_KEYFRAMES   = 8,
  parameter int CURVE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: frame_count[15:0], key_index[18:16], key_position[35:19],
  // key_value[52:36], zero pad
  input  logic [55:0] s_axis_tdata,
  // tuser: opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: level[23:0], curve_value[40:24], zero pad
  output logic [47:0] m_axis_tdata
);
  localparam int F  = CURVE_FRAC_BITS;
  localparam int KI = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int KC = $clog2(MAX_KEYFRAMES + 1);
  localparam int DW = 2 * F + 4;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  tlcs_pkg::state_t state, state_next;

  logic        enable;
  logic [1:0]  curve_mode;
  logic signed [23:0] start_level, end_level;
  logic [31:0] phase_step;
  logic [3:0]  keyframe_count;
  logic [32:0] phase;

  logic [16:0] kpos_mem [MAX_KEYFRAMES];
  logic [16:0] kval_mem [MAX_KEYFRAMES];

  logic [15:0] frames;
  logic [F:0]  t;
  logic signed [35:0] c;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic [KI-1:0] ki;
  logic [KC-1:0] nk;
  logic [16:0] p0, p1, v0, v1;
  logic [DW-1:0] div_num, div_den, div_q;
  logic        div_start, div_done, div_neg;
  logic [23:0] level_out;
  logic        in_fire;
  logic [DW-1:0] dv_mag;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == tlcs_pkg::ST_IDLE);
  assign prod = ma * mb;

  // Keyframe position or value, Q1.16 in, rescaled to Q1.F
  function automatic logic [F:0] qf(input logic [16:0] x);
    if (F >= 16) return (F+1)'({x, {(F >= 16 ? F-16+1 : 1){1'b0}}} >> 1);
    else return (F+1)'(x >> (16 - F));
  endfunction

  // Effective keyframe count, clamped to table size
  always_comb begin
    if (32'(keyframe_count) > MAX_KEYFRAMES) nk = KC'(MAX_KEYFRAMES);
    else nk = KC'(keyframe_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0; curve_mode <= '0; start_level <= '0; end_level <= '0;
      phase_step <= '0; keyframe_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlcs_pkg::REG_ENABLE: enable <= cfg_data[0];
        tlcs_pkg::REG_MODE:   curve_mode <= cfg_data[1:0];
        tlcs_pkg::REG_START:  start_level <= cfg_data[23:0];
        tlcs_pkg::REG_END:    end_level <= cfg_data[23:0];
        tlcs_pkg::REG_STEP:   phase_step <= cfg_data;
        tlcs_pkg::REG_KCOUNT: keyframe_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Keyframe table write on load transactions; index beyond the table drops
  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tuser == tlcs_pkg::OP_LOAD &&
        32'(s_axis_tdata[18:16]) < MAX_KEYFRAMES) begin
      kpos_mem[KI'(s_axis_tdata[18:16])] <= s_axis_tdata[35:19];
      kval_mem[KI'(s_axis_tdata[18:16])] <= s_axis_tdata[52:36];
    end
  end

  assign p0 = kpos_mem[ki];
  assign v0 = kval_mem[ki];
  assign p1 = kpos_mem[(ki == KI'(MAX_KEYFRAMES - 1)) ? ki : ki + 1'b1];
  assign v1 = kval_mem[(ki == KI'(MAX_KEYFRAMES - 1)) ? ki : ki + 1'b1];
  assign dv_mag = v1 >= v0 ? DW'(qf(v1) - qf(v0)) : DW'(qf(v0) - qf(v1));

  tlcs_divider #(.W(DW)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_num), .divisor(div_den),
    .done(div_done), .quotient(div_q)
  );

  // Multiplier operand select
  logic [16:0] rb_p;
  logic [F+3:0] x8;
  logic [3:0]  rb_n;
  logic [4:0]  rb_idx;
  logic [F-5:0] rb_rem;
  assign x8 = {t, 3'b000};
  assign rb_n = (x8[F+3:F] > 4'd8) ? 4'd8 : x8[F+3:F];
  assign rb_idx = {1'b0, x8[F-1:F-4]};
  assign rb_rem = x8[F-5:0];
  assign rb_p = tlcs_pkg::exp2_neg(rb_idx) - 17'(prod >>> (F - 4));

  always_comb begin
    ma = '0; mb = '0;
    unique case (state)
      tlcs_pkg::ST_MUL: begin
        ma = 34'(frames); mb = 34'(phase_step);
      end
      tlcs_pkg::ST_SHAPE1: begin
        if (curve_mode == tlcs_pkg::MODE_SMOOTH) begin
          ma = 34'(t); mb = 34'(t);
        end else begin
          ma = 34'(tlcs_pkg::exp2_neg(rb_idx) - tlcs_pkg::exp2_neg(rb_idx + 5'd1));
          mb = 34'(rb_rem);
        end
      end
      tlcs_pkg::ST_SHAPE2: begin
        ma = 34'(c); mb = 34'((3 * ONE) - 2 * t);
      end
      // Segment numerator |v1 - v0| * (t - p0)
      tlcs_pkg::ST_KEY: begin
        ma = 34'(dv_mag); mb = 34'(t - qf(p0));
      end
      tlcs_pkg::ST_LVL: begin
        ma = 34'(end_level) - 34'(start_level); mb = 34'(c);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlcs_pkg::ST_IDLE:
        if (in_fire && s_axis_tuser == tlcs_pkg::OP_TICK && enable)
          state_next = tlcs_pkg::ST_MUL;
      tlcs_pkg::ST_MUL: state_next = tlcs_pkg::ST_FOLD;
      tlcs_pkg::ST_FOLD: begin
        unique case (curve_mode)
          tlcs_pkg::MODE_LINEAR: state_next = tlcs_pkg::ST_CLAMP;
          tlcs_pkg::MODE_KEY:    state_next = tlcs_pkg::ST_KEY;
          default:               state_next = tlcs_pkg::ST_SHAPE1;
        endcase
      end
      tlcs_pkg::ST_SHAPE1:
        state_next = (curve_mode == tlcs_pkg::MODE_SMOOTH) ? tlcs_pkg::ST_SHAPE2
                                                           : tlcs_pkg::ST_CLAMP;
      tlcs_pkg::ST_SHAPE2: state_next = tlcs_pkg::ST_CLAMP;
      tlcs_pkg::ST_KEY: begin
        if (nk < KC'(2) || t <= qf(kpos_mem[0]) ||
            t >= qf(kpos_mem[KI'(nk - 1'b1)]) || KC'(ki) + 2 > nk)
          state_next = tlcs_pkg::ST_CLAMP;
        else if (t >= qf(p0) && t <= qf(p1))
          state_next = (qf(p1) > qf(p0)) ? tlcs_pkg::ST_KDIV : tlcs_pkg::ST_CLAMP;
      end
      tlcs_pkg::ST_KDIV: if (div_done) state_next = tlcs_pkg::ST_CLAMP;
      tlcs_pkg::ST_CLAMP: state_next = tlcs_pkg::ST_LVL;
      tlcs_pkg::ST_LVL: state_next = tlcs_pkg::ST_OUT;
      tlcs_pkg::ST_OUT: if (m_axis_tready) state_next = tlcs_pkg::ST_IDLE;
      default: state_next = tlcs_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = (state == tlcs_pkg::ST_OUT);

  logic [32:0] ph_sum;
  logic [32:0] folded;
  logic signed [67:0] lsum;
  logic signed [47:0] lvl_w;
  assign ph_sum = phase + prod[32:0];
  assign folded = (phase <= 33'h100000000) ? phase
                                           : 33'(34'h200000000 - 34'(phase));
  assign lsum = prod + 68'(ONE >> 1);
  assign lvl_w = 48'(start_level) + 48'(lsum >>> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlcs_pkg::ST_IDLE;
      phase <= '0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      div_start <= 1'b0;
      if (state == tlcs_pkg::ST_MUL) phase <= ph_sum;
      if (state == tlcs_pkg::ST_KEY && state_next == tlcs_pkg::ST_KDIV)
        div_start <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tlcs_pkg::ST_IDLE: if (in_fire) frames <= s_axis_tdata[15:0];
      tlcs_pkg::ST_FOLD: begin
        t <= (F+1)'(folded >> (32 - F));
        c <= 36'(folded >> (32 - F));
        ki <= '0;
      end
      tlcs_pkg::ST_SHAPE1: begin
        if (curve_mode == tlcs_pkg::MODE_SMOOTH)
          c <= 36'((prod + 68'(ONE >> 1)) >>> F);
        else
          c <= 36'(ONE) - 36'((68'(rb_p) << F) >> (16 + rb_n));
      end
      tlcs_pkg::ST_SHAPE2: c <= 36'((prod + 68'(ONE >> 1)) >>> F);
      tlcs_pkg::ST_KEY: begin
        if (nk == '0) c <= 36'(t);
        else if (nk == KC'(1) || t <= qf(kpos_mem[0])) c <= 36'(qf(kval_mem[0]));
        else if (t >= qf(kpos_mem[KI'(nk - 1'b1)]) || KC'(ki) + 2 > nk)
          c <= 36'(qf(kval_mem[KI'(nk - 1'b1)]));
        else if (t >= qf(p0) && t <= qf(p1)) begin
          c <= 36'(qf(v0));
          div_neg <= v1 < v0;
          div_num <= DW'(prod);
          div_den <= DW'(qf(p1) - qf(p0));
        end else ki <= ki + 1'b1;
      end
      tlcs_pkg::ST_KDIV:
        if (div_done) c <= div_neg ? c - 36'(div_q) : c + 36'(div_q);
      tlcs_pkg::ST_CLAMP:
        if (c < 0) c <= '0;
        else if (c > 36'(ONE)) c <= 36'(ONE);
      tlcs_pkg::ST_LVL:
        if (lvl_w > 48'sd8388607) level_out <= 24'h7FFFFF;
        else if (lvl_w < -48'sd8388608) level_out <= 24'h800000;
        else level_out <= lvl_w[23:0];
      default: ;
    endcase
  end

  logic [16:0] cv16;
  assign cv16 = (F >= 16) ? 17'(c >> (F >= 16 ? F - 16 : 0))
                          : 17'(c << (F < 16 ? 16 - F : 0));
  assign m_axis_tdata = {7'd0, cv16, level_out};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_phase: assert property (@(posedge clk) disable iff (rst)
    state == tlcs_pkg::ST_IDLE && !in_fire |=> $stable(phase))
    else $error("phase moved while idle");
endmodule
